### rtl/lds_pkg.sv
// ----------------------------------------------------------------------------
// lds_pkg: shared definitions for the LOOK disk scheduler
// Sizes, register indexes, status codes and controller/datapath structs.
// ----------------------------------------------------------------------------
package lds_pkg;

	// Capacity of one batch and width of a stored cylinder.
	localparam int MAX_REQUESTS = 64;
	localparam int CYL_BITS     = 16;

	// Fixed field widths of the channels and the configuration port.
	localparam int CYL_FIELD_W = 16;
	localparam int MOVE_W      = 22;
	localparam int STATUS_W    = 2;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	// Derived sizes.
	localparam int IDX_BITS = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
	localparam int CNT_BITS = $clog2(MAX_REQUESTS + 1);
	localparam int WIDE_W   = (CYL_BITS > CYL_FIELD_W) ? CYL_BITS : CYL_FIELD_W;

	localparam logic [MOVE_W-1:0] MOVE_MAX = {MOVE_W{1'b1}};

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DISK_SIZE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_START_HEAD  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_RIGHT = 2'd2;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_INVALID  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic store;        // write the incoming request, bump the count
		logic err;          // load an error result, drop the batch
		logic begin_batch;  // head to start position, clear marks and sums
		logic scan_init;    // restart the scan over the stored requests
		logic scan_step;    // issue one store read
		logic flip_side;    // switch to the other sweep direction
		logic emit;         // load the picked request as a result
		logic finish;       // batch done, empty the store
	} lds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic invalid;      // incoming cylinder exceeds the disk size
		logic overflow;     // store already full
		logic scan_last;    // the read being issued is the last entry
		logic found;        // the scan found a candidate
		logic last_pick;    // the next result is the final one of the batch
		logic out_free;     // result register can take a new result
	} lds_sts_t;

	// Bring a request field to the stored cylinder width.
	function automatic logic [CYL_BITS-1:0] to_cyl(input logic [CYL_FIELD_W-1:0] c);
		logic [63:0] w;
		w = 64'(c);
		return w[CYL_BITS-1:0];
	endfunction

endpackage

### rtl/lds_req_if.sv
// ----------------------------------------------------------------------------
// lds_req_if: request channel
// Valid/ready channel carrying one cylinder request per transaction.
// ----------------------------------------------------------------------------
interface lds_req_if;
	logic                             valid;
	logic                             ready;
	logic [lds_pkg::CYL_FIELD_W-1:0] cylinder;
	logic                             batch_end;

	modport source(output valid, output cylinder, output batch_end, input ready);
	modport sink(input valid, input cylinder, input batch_end, output ready);
endinterface

### rtl/lds_res_if.sv
// ----------------------------------------------------------------------------
// lds_res_if: result channel
// Valid/ready channel carrying one served cylinder per transaction.
// ----------------------------------------------------------------------------
interface lds_res_if;
	logic                             valid;
	logic                             ready;
	logic [lds_pkg::CYL_FIELD_W-1:0] served_cylinder;
	logic [lds_pkg::MOVE_W-1:0]      total_movement;
	logic [lds_pkg::STATUS_W-1:0]    status;
	logic                             run_last;

	modport source(output valid, output served_cylinder, output total_movement,
		output status, output run_last, input ready);
	modport sink(input valid, input served_cylinder, input total_movement,
		input status, input run_last, output ready);
endinterface

### rtl/lds_dp.sv
// ----------------------------------------------------------------------------
// lds_dp: scheduler datapath
// Configuration registers, request store, scan compare, head and movement
// tracking, and the result register.
// ----------------------------------------------------------------------------
module lds_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [lds_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lds_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  logic [lds_pkg::CYL_FIELD_W-1:0]  cylinder,
	input  lds_pkg::lds_cmd_t                cmd,
	output lds_pkg::lds_sts_t                sts,
	input  logic                              res_ready,
	output logic                              res_valid,
	output logic [lds_pkg::CYL_FIELD_W-1:0]  res_served_cylinder,
	output logic [lds_pkg::MOVE_W-1:0]       res_total_movement,
	output logic [lds_pkg::STATUS_W-1:0]     res_status,
	output logic                              res_run_last
);

	localparam int W = lds_pkg::WIDE_W;

	logic [15:0]                     disk_size_q;
	logic [15:0]                     start_head_q;
	logic                            sweep_right_q;

	logic [lds_pkg::CYL_BITS-1:0]   store_mem [lds_pkg::MAX_REQUESTS];
	logic [lds_pkg::CNT_BITS-1:0]   count_q;
	logic [lds_pkg::CNT_BITS-1:0]   served_q;
	logic [lds_pkg::MAX_REQUESTS-1:0] marks_q;

	logic [lds_pkg::IDX_BITS-1:0]   idx_q;
	logic                            valid_s1;
	logic [lds_pkg::CYL_BITS-1:0]   rdata_s1;
	logic [lds_pkg::IDX_BITS-1:0]   idx_s1;
	logic                            mark_s1;

	logic                            side_q;
	logic                            found_q;
	logic [W-1:0]                    best_q;
	logic [lds_pkg::IDX_BITS-1:0]   best_idx_q;

	logic [W-1:0]                    head_q;
	logic [lds_pkg::MOVE_W-1:0]     sum_q;

	logic [lds_pkg::CYL_BITS-1:0]   cyl_in;
	logic [W-1:0]                    v_s1;
	logic [W-1:0]                    start_w;
	logic                            upper_side;
	logic                            better;
	logic                            take;
	logic [W-1:0]                    travel;
	logic [32:0]                     sum_wide;
	logic [lds_pkg::MOVE_W-1:0]     sum_next;

	assign cyl_in  = lds_pkg::to_cyl(cylinder);
	assign v_s1    = W'(rdata_s1);
	assign start_w = W'(start_head_q);

	// Candidate test on the entry just read.
	assign upper_side = (v_s1 >= start_w);
	assign better     = side_q ? (v_s1 < best_q) : (v_s1 > best_q);
	assign take       = valid_s1 && !mark_s1 && (upper_side == side_q) &&
		(!found_q || better);

	// Movement to the picked cylinder, saturating.
	assign travel   = (best_q > head_q) ? (best_q - head_q) : (head_q - best_q);
	assign sum_wide = 33'(sum_q) + 33'(travel);
	assign sum_next = (sum_wide > 33'(lds_pkg::MOVE_MAX)) ? lds_pkg::MOVE_MAX
		: sum_wide[lds_pkg::MOVE_W-1:0];

	assign sts.invalid   = (W'(cyl_in) > W'(disk_size_q));
	assign sts.overflow  = (count_q >= lds_pkg::CNT_BITS'(lds_pkg::MAX_REQUESTS));
	assign sts.scan_last = (lds_pkg::CNT_BITS'(idx_q) == (count_q - 1'b1));
	assign sts.found     = found_q;
	assign sts.last_pick = (served_q == (count_q - 1'b1));
	assign sts.out_free  = !res_valid || res_ready;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			disk_size_q   <= 16'hFFFF;
			start_head_q  <= '0;
			sweep_right_q <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lds_pkg::CFG_DISK_SIZE:   disk_size_q   <= cfg_wdata;
				lds_pkg::CFG_START_HEAD:  start_head_q  <= cfg_wdata;
				lds_pkg::CFG_SWEEP_RIGHT: sweep_right_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// Request store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_mem[count_q[lds_pkg::IDX_BITS-1:0]] <= cyl_in;
		end
		if (cmd.scan_step) begin
			rdata_s1 <= store_mem[idx_q];
			idx_s1   <= idx_q;
			mark_s1  <= marks_q[idx_q];
		end
	end

	// Batch control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			served_q <= '0;
			marks_q  <= '0;
			idx_q    <= '0;
			valid_s1 <= 1'b0;
			side_q   <= 1'b0;
			found_q  <= 1'b0;
			head_q   <= '0;
			sum_q    <= '0;
		end else begin
			valid_s1 <= cmd.scan_step;
			if (cmd.err || cmd.finish) begin
				count_q <= '0;
			end else if (cmd.store) begin
				count_q <= count_q + 1'b1;
			end
			if (cmd.begin_batch) begin
				marks_q  <= '0;
				served_q <= '0;
				head_q   <= start_w;
				sum_q    <= '0;
				side_q   <= sweep_right_q;
			end else begin
				if (cmd.flip_side) begin
					side_q <= !side_q;
				end
				if (cmd.emit) begin
					marks_q[best_idx_q] <= 1'b1;
					served_q            <= served_q + 1'b1;
					head_q              <= best_q;
					sum_q               <= sum_next;
				end
			end
			if (cmd.scan_init) begin
				idx_q   <= '0;
				found_q <= 1'b0;
			end else begin
				if (cmd.scan_step) begin
					idx_q <= idx_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// Best candidate of the current scan.
	always_ff @(posedge clk) begin
		if (take && !cmd.scan_init) begin
			best_q     <= v_s1;
			best_idx_q <= idx_s1;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (cmd.err || cmd.emit) begin
			res_valid <= 1'b1;
		end else if (res_ready) begin
			res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.err) begin
			res_served_cylinder <= '0;
			res_total_movement  <= '0;
			res_status          <= sts.invalid ? lds_pkg::ST_INVALID : lds_pkg::ST_OVERFLOW;
			res_run_last        <= 1'b1;
		end else if (cmd.emit) begin
			res_served_cylinder <= best_q[lds_pkg::CYL_FIELD_W-1:0];
			res_total_movement  <= sum_next;
			res_status          <= lds_pkg::ST_OK;
			res_run_last        <= sts.last_pick;
		end
	end

endmodule

### rtl/lds_ctrl.sv
// ----------------------------------------------------------------------------
// lds_ctrl: scheduler controller
// Sequences loading, the selection scans of both sweep sides, and emission.
// ----------------------------------------------------------------------------
module lds_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_batch_end,
	output logic              req_ready,
	input  lds_pkg::lds_sts_t sts,
	output lds_pkg::lds_cmd_t cmd
);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SCAN   = 2'd1;
	localparam logic [1:0] S_DRAIN  = 2'd2;
	localparam logic [1:0] S_DECIDE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       first_side_q;
	logic       accept;

	assign req_ready = (state_q == S_IDLE) && sts.out_free;
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (sts.invalid || sts.overflow) begin
						cmd.err = 1'b1;
					end else begin
						cmd.store = 1'b1;
						if (req_batch_end) begin
							cmd.begin_batch = 1'b1;
							cmd.scan_init   = 1'b1;
							state_d         = S_SCAN;
						end
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (sts.found) begin
					if (sts.out_free) begin
						cmd.emit = 1'b1;
						if (sts.last_pick) begin
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end else begin
							cmd.scan_init = 1'b1;
							state_d       = S_SCAN;
						end
					end
				end else if (first_side_q) begin
					cmd.flip_side = 1'b1;
					cmd.scan_init = 1'b1;
					state_d       = S_SCAN;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			first_side_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.begin_batch) begin
				first_side_q <= 1'b1;
			end else if (cmd.flip_side) begin
				first_side_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/look_disk_scheduler.sv
// A good request that does not end its batch gives no result.
// An error result is registered and appears in the cycle after the offending transaction.
// A batch of N requests takes one scan of all N stored entries per served cylinder, plus
// one more scan whenever the side served second is not empty.
// That time is set by the single read port of the request store, swept once per pick.
// Reset is asynchronous, active low; it restores the default configuration and empties the store.
// ----------------------------------------------------------------------------
// look_disk_scheduler: LOOK disk-arm scheduler
// Collects a batch of cylinder requests and emits them in LOOK service order
// together with the running total head movement.
// ----------------------------------------------------------------------------
module look_disk_scheduler (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [lds_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lds_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	lds_req_if.sink                          req,
	lds_res_if.source                        res
);

	// The controller and the datapath talk only through these two groups.
	lds_pkg::lds_cmd_t cmd;
	lds_pkg::lds_sts_t sts;

	// The controller owns the request handshake. Requests are taken one per
	// cycle while no batch is being ordered and the result register can
	// accept an error result, should the request turn out to be bad.
	// Once the final request of a batch is taken, the controller repeatedly
	// sweeps the request store: each sweep finds the nearest unserved request
	// in the current direction, and each find becomes one result transaction.
	// When the first direction runs dry the controller turns to the other one.
	lds_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req.valid),
		.req_batch_end (req.batch_end),
		.req_ready     (req.ready),
		.sts           (sts),
		.cmd           (cmd)
	);

	// The datapath holds the configuration registers, the request store, the
	// per-entry served marks, the head position and movement sum, and the
	// result register that drives the result channel.
	lds_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_wdata           (cfg_wdata),
		.cylinder            (req.cylinder),
		.cmd                 (cmd),
		.sts                 (sts),
		.res_ready           (res.ready),
		.res_valid           (res.valid),
		.res_served_cylinder (res.served_cylinder),
		.res_total_movement  (res.total_movement),
		.res_status          (res.status),
		.res_run_last        (res.run_last)
	);

endmodule
